// ===== src/sand_pkg.sv =====
package sand_pkg;

	localparam int GRID_SIZE = 64;
	localparam int IDX_W = 6;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int COUNT_W = 13;

	localparam logic [1:0] OP_FILL = 2'd0;
	localparam logic [1:0] OP_STEP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [0:0] REG_FILL_VALUE = 1'b0;
	localparam logic [0:0] REG_DROP_IN_CENTER = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] row_index;
		logic [5:0] col_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] cell_value;
		logic [12:0] unstable_count;
		logic grain_dropped;
		logic ever_dropped;
	} out_item_t;

endpackage

// ===== src/sandpile_automaton_step.sv =====
// a step with no unstable cell runs a count pass and drops one grain; a step with
// unstable cells runs a count pass, a topple pass and a copy-back pass
// throughput: one item at a time; each pass walks the grid one cell per cycle
// through grid memories with one read and one write port
// reset: grid zero via a clearing pass before the first item,
// fill_value 0, drop_in_center 1, ever_dropped 0
module sandpile_automaton_step (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sand_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output sand_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [1:0] cfg_wdata
);

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_FILL = 4'd2;
	localparam logic [3:0] S_CNT = 4'd3;
	localparam logic [3:0] S_DROP_RD = 4'd4;
	localparam logic [3:0] S_DROP_WR = 4'd5;
	localparam logic [3:0] S_TOP = 4'd6;
	localparam logic [3:0] S_COPY = 4'd7;
	localparam logic [3:0] S_READ = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;
	localparam logic [3:0] S_DROP_W2 = 4'd10;
	localparam logic [3:0] S_READ2 = 4'd11;

	localparam int AW = sand_pkg::ADDR_W;
	localparam int LAT = 2 * sand_pkg::GRID_SIZE + 2;

	logic [3:0] state_q;
	logic [1:0] fill_q;
	logic center_q;
	logic ever_q;
	sand_pkg::in_item_t item_q;
	sand_pkg::out_item_t res_q;
	logic [AW:0] cnt_q;
	logic [AW+1:0] tcnt_q;
	logic [sand_pkg::COUNT_W-1:0] ucnt_q;

	// grid memory and next-grid memory
	logic [2:0] grid_mem [sand_pkg::CELLS];
	logic [2:0] next_mem [sand_pkg::CELLS];
	logic [2:0] grid_rd_q;
	logic [2:0] next_rd_q;
	logic g_we, n_we;
	logic [AW-1:0] g_waddr, g_raddr, n_waddr, n_raddr;
	logic [2:0] g_wdata, n_wdata;

	always_ff @(posedge clk) begin
		if (g_we) grid_mem[g_waddr] <= g_wdata;
		grid_rd_q <= grid_mem[g_raddr];
	end

	always_ff @(posedge clk) begin
		if (n_we) next_mem[n_waddr] <= n_wdata;
		next_rd_q <= next_mem[n_raddr];
	end

	// topple window: stream cells in raster order through a shift-register window holding the neighbours
	logic [2:0] win_q [LAT];
	logic [AW:0] pos_s1;
	logic vld_s1;
	logic [AW:0] pos_c;
	logic [AW-1:0] cpos;
	logic [sand_pkg::IDX_W-1:0] cr, cc;
	logic [2:0] vc, vsum;
	logic [3:0] sum;
	logic [2:0] gain;
	logic up_u, dn_u, lf_u, rt_u;

	// cell being centered is at stream index tcnt - (GRID+2), behind the read register and the window
	assign pos_c = tcnt_q[AW:0] - (AW+1)'(sand_pkg::GRID_SIZE + 2);
	assign cpos = pos_c[AW-1:0];
	assign cr = cpos[AW-1 -: sand_pkg::IDX_W];
	assign cc = cpos[sand_pkg::IDX_W-1:0];
	assign vc = win_q[sand_pkg::GRID_SIZE];
	assign dn_u = (cr != sand_pkg::IDX_W'(sand_pkg::GRID_SIZE - 1)) && win_q[0][2];
	assign rt_u = (cc != sand_pkg::IDX_W'(sand_pkg::GRID_SIZE - 1))
		&& win_q[sand_pkg::GRID_SIZE - 1][2];
	assign lf_u = (cc != '0) && win_q[sand_pkg::GRID_SIZE + 1][2];
	assign up_u = (cr != '0) && win_q[2 * sand_pkg::GRID_SIZE][2];
	assign gain = 3'(up_u) + 3'(dn_u) + 3'(lf_u) + 3'(rt_u);
	assign vsum = vc[2] ? {1'b0, vc[1:0]} : vc;
	assign sum = {1'b0, vsum} + {1'b0, gain};

	always_ff @(posedge clk) begin
		win_q[0] <= (tcnt_q[AW+1:0] >= (AW+2)'(1) && tcnt_q <= (AW+2)'(sand_pkg::CELLS))
			? grid_rd_q : 3'd0;
		for (int i = 1; i < LAT; i++) win_q[i] <= win_q[i-1];
	end

	assign vld_s1 = state_q == S_TOP && tcnt_q >= (AW+2)'(sand_pkg::GRID_SIZE + 2);
	assign pos_s1 = pos_c;

	logic [AW-1:0] drop_addr;
	logic drop_in;
	always_comb begin
		drop_addr = center_q
			? {sand_pkg::IDX_W'(sand_pkg::GRID_SIZE / 2), sand_pkg::IDX_W'(sand_pkg::GRID_SIZE / 2)}
			: {item_q.row_index, item_q.col_index};
		drop_in = 1'b1;
	end

	always_comb begin
		g_we = 1'b0;
		g_waddr = cnt_q[AW-1:0];
		g_wdata = 3'd0;
		g_raddr = cnt_q[AW-1:0];
		n_we = 1'b0;
		n_waddr = pos_s1[AW-1:0];
		n_wdata = sum[3] ? 3'd7 : sum[2:0];
		n_raddr = cnt_q[AW-1:0];
		unique case (state_q)
			S_CLR: g_we = 1'b1;
			S_FILL: begin
				g_we = 1'b1;
				g_wdata = {1'b0, fill_q};
			end
			S_DROP_RD, S_DROP_W2: g_raddr = drop_addr;
			S_DROP_WR: begin
				g_we = drop_in;
				g_waddr = drop_addr;
				g_wdata = (grid_rd_q == 3'd7) ? 3'd7 : grid_rd_q + 3'd1;
			end
			S_TOP: begin
				g_raddr = tcnt_q[AW-1:0];
				n_we = vld_s1;
			end
			S_COPY: begin
				g_we = cnt_q != '0;
				g_waddr = cnt_q[AW-1:0] - AW'(1);
				g_wdata = next_rd_q;
			end
			S_READ, S_READ2: g_raddr = {item_q.row_index, item_q.col_index};
			default: ;
		endcase
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			fill_q <= 2'd0;
			center_q <= 1'b1;
			ever_q <= 1'b0;
			cnt_q <= '0;
			tcnt_q <= '0;
			ucnt_q <= '0;
			item_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sand_pkg::REG_FILL_VALUE: fill_q <= cfg_wdata;
					sand_pkg::REG_DROP_IN_CENTER: center_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLR, S_FILL: begin
					if (cnt_q[AW-1:0] == AW'(sand_pkg::CELLS - 1)) begin
						cnt_q <= '0;
						state_q <= (state_q == S_CLR) ? S_IDLE : S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						cnt_q <= '0;
						tcnt_q <= '0;
						ucnt_q <= '0;
						res_q <= '{cell_value: 3'd0, unstable_count: '0,
							grain_dropped: 1'b0, ever_dropped: ever_q};
						unique case (in_data.opcode)
							sand_pkg::OP_FILL: state_q <= S_FILL;
							sand_pkg::OP_STEP: state_q <= S_CNT;
							sand_pkg::OP_READ: state_q <= S_READ;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CNT: begin
					if (cnt_q != '0 && grid_rd_q[2]) ucnt_q <= ucnt_q + 1'b1;
					if (cnt_q == (AW+1)'(sand_pkg::CELLS)) begin
						cnt_q <= '0;
						res_q.unstable_count <= (cnt_q != '0 && grid_rd_q[2])
							? ucnt_q + 1'b1 : ucnt_q;
						if (ucnt_q == '0 && !grid_rd_q[2]) state_q <= S_DROP_RD;
						else state_q <= S_TOP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DROP_RD: state_q <= S_DROP_W2;
				S_DROP_W2: state_q <= S_DROP_WR;
				S_DROP_WR: begin
					ever_q <= 1'b1;
					res_q <= '{cell_value: res_q.cell_value,
						unstable_count: res_q.unstable_count,
						grain_dropped: 1'b1, ever_dropped: 1'b1};
					state_q <= S_OUT;
				end
				S_TOP: begin
					tcnt_q <= tcnt_q + 1'b1;
					if (tcnt_q == (AW+2)'(sand_pkg::CELLS + sand_pkg::GRID_SIZE + 1)) begin
						cnt_q <= '0;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (AW+1)'(sand_pkg::CELLS)) state_q <= S_OUT;
				end
				S_READ: state_q <= S_READ2;
				S_READ2: begin
					res_q.cell_value <= grid_rd_q;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
